// ===== hdl/tsp2lb_pkg.sv =====
// Shared types and constants for the edge-pair TSP lower bound block.
package tsp2lb_pkg;

  localparam int unsigned CostW   = 16;
  localparam int unsigned MarkW   = 2;
  localparam int unsigned RowSumW = CostW + 1;
  localparam int unsigned TotalW  = 23;
  localparam int unsigned BoundW  = 22;

  localparam logic [TotalW-1:0] TotalMax = '1;
  localparam logic [BoundW-1:0] BoundMax = '1;

  // Edge marks; the unused code behaves like excluded.
  typedef enum logic [MarkW-1:0] {
    MarkFree = 2'd0,
    MarkIncl = 2'd1,
    MarkExcl = 2'd2
  } mark_e;

  // Classified matrix entry handed from the front to the back.
  typedef struct packed {
    logic [CostW-1:0] cost;
    logic             is_free;
    logic             is_incl;
    logic             close;
    logic             mend;
  } entry_t;

  // Closed row handed from the row stage to the accumulator.
  typedef struct packed {
    logic [RowSumW-1:0] sum;
    logic               ok;
    logic               mend;
  } row_t;

endpackage

// ===== hdl/tsp2lb_front.sv =====
// Front end: accepts matrix entries, classifies them and queues them for the back end.
module tsp2lb_front #(
  parameter int unsigned COST_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tsp2lb_pkg::CostW-1:0]     edge_cost_i,
  input  logic [tsp2lb_pkg::MarkW-1:0]     edge_mark_i,
  input  logic                             row_end_i,
  input  logic                             matrix_end_i,
  output logic                             ent_valid_o,
  output tsp2lb_pkg::entry_t               ent_o,
  input  logic                             ent_pop_i
);

  localparam int unsigned KeepBits = (COST_BITS < tsp2lb_pkg::CostW) ? COST_BITS
                                                                    : tsp2lb_pkg::CostW;
  localparam logic [tsp2lb_pkg::CostW-1:0] CostMask =
    tsp2lb_pkg::CostW'((33'(1) << KeepBits) - 33'(1));
  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  tsp2lb_pkg::entry_t ent_in;
  tsp2lb_pkg::entry_t queue_q [QDepth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               push, pop;

  // Classify the entry; the unused mark code counts as excluded.
  always_comb begin
    ent_in.cost    = edge_cost_i & CostMask;
    ent_in.is_free = 1'b0;
    ent_in.is_incl = 1'b0;
    ent_in.close   = row_end_i | matrix_end_i;
    ent_in.mend    = matrix_end_i;
    case (tsp2lb_pkg::mark_e'(edge_mark_i))
      tsp2lb_pkg::MarkFree: ent_in.is_free = 1'b1;
      tsp2lb_pkg::MarkIncl: ent_in.is_incl = 1'b1;
      tsp2lb_pkg::MarkExcl: ;
      default: ;
    endcase
  end

  assign in_ready_o  = (cnt_q != CntW'(QDepth));
  assign push        = in_valid_i & in_ready_o;
  assign ent_valid_o = (cnt_q != '0);
  assign pop         = ent_valid_o & ent_pop_i;
  assign ent_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop  ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= ent_in;
    end
  end

endmodule

// ===== hdl/tsp2lb_back.sv =====
// Back end: per-row edge selection, bound accumulation and the result register.
module tsp2lb_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              ent_valid_i,
  input  tsp2lb_pkg::entry_t                ent_i,
  output logic                              ent_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tsp2lb_pkg::BoundW-1:0]     lower_bound_o,
  output logic                              no_bound_o
);

  localparam int unsigned CostW   = tsp2lb_pkg::CostW;
  localparam int unsigned RowSumW = tsp2lb_pkg::RowSumW;
  localparam int unsigned TotalW  = tsp2lb_pkg::TotalW;
  localparam int unsigned BoundW  = tsp2lb_pkg::BoundW;

  // Row state: two cheapest free edges and the first two included edges.
  logic [CostW-1:0] f1_q, f1_d, f1_n, f2_q, f2_d, f2_n;
  logic             f1v_q, f1v_d, f1v_n, f2v_q, f2v_d, f2v_n;
  logic [CostW-1:0] inc1_q, inc1_d, inc1_n, inc2_q, inc2_d, inc2_n;
  logic [1:0]       icnt_q, icnt_d, icnt_n;

  tsp2lb_pkg::row_t row_q, row_d, row_n;
  logic             row_v_q, row_v_d;

  logic [TotalW-1:0] acc_q, acc_d, out_total_q, out_total_d;
  logic              miss_q, miss_d, out_miss_q, out_miss_d;
  logic              out_valid_q, out_valid_d;

  logic              a_free, b_take, pop, out_load;
  logic [TotalW:0]   acc_sum;
  logic [TotalW-1:0] acc_sat;
  logic              miss_new;
  logic [TotalW-1:0] half_up;

  assign b_take    = row_v_q & (!row_q.mend | !out_valid_q | out_ready_i);
  assign a_free    = !row_v_q | b_take;
  assign pop       = ent_valid_i & (!ent_i.close | a_free);
  assign ent_pop_o = pop;

  // Fold the current entry into the row state, then form the row's sum over its chosen edge pair.
  always_comb begin
    f1_n   = f1_q;
    f1v_n  = f1v_q;
    f2_n   = f2_q;
    f2v_n  = f2v_q;
    inc1_n = inc1_q;
    inc2_n = inc2_q;
    icnt_n = icnt_q;
    if (ent_i.is_incl) begin
      case (icnt_q)
        2'd0: begin
          inc1_n = ent_i.cost;
          icnt_n = 2'd1;
        end
        2'd1: begin
          inc2_n = ent_i.cost;
          icnt_n = 2'd2;
        end
        default: ;
      endcase
    end
    if (ent_i.is_free) begin
      // A tie with the cheapest becomes the second cheapest.
      if (!f1v_q || ent_i.cost < f1_q) begin
        f2_n  = f1_q;
        f2v_n = f1v_q;
        f1_n  = ent_i.cost;
        f1v_n = 1'b1;
      end else if (!f2v_q || ent_i.cost < f2_q) begin
        f2_n  = ent_i.cost;
        f2v_n = 1'b1;
      end
    end

    row_n.mend = ent_i.mend;
    case (icnt_n)
      2'd0: begin
        row_n.sum = RowSumW'(f1_n) + RowSumW'(f2_n);
        row_n.ok  = f2v_n;
      end
      2'd1: begin
        row_n.sum = RowSumW'(inc1_n) + RowSumW'(f1_n);
        row_n.ok  = f1v_n;
      end
      default: begin
        row_n.sum = RowSumW'(inc1_n) + RowSumW'(inc2_n);
        row_n.ok  = 1'b1;
      end
    endcase
  end

  always_comb begin
    f1_d    = f1_q;
    f1v_d   = f1v_q;
    f2_d    = f2_q;
    f2v_d   = f2v_q;
    inc1_d  = inc1_q;
    inc2_d  = inc2_q;
    icnt_d  = icnt_q;
    row_d   = row_q;
    row_v_d = row_v_q & !b_take;
    if (pop) begin
      if (ent_i.close) begin
        // Hand the closed row on and start a clean row.
        row_d   = row_n;
        row_v_d = 1'b1;
        f1v_d   = 1'b0;
        f2v_d   = 1'b0;
        icnt_d  = 2'd0;
      end else begin
        f1_d   = f1_n;
        f1v_d  = f1v_n;
        f2_d   = f2_n;
        f2v_d  = f2v_n;
        inc1_d = inc1_n;
        inc2_d = inc2_n;
        icnt_d = icnt_n;
      end
    end
  end

  // Accumulate closed rows with saturation; load the result on the matrix end.
  always_comb begin
    acc_sum  = {1'b0, acc_q} + (row_q.ok ? (TotalW + 1)'(row_q.sum) : '0);
    acc_sat  = acc_sum[TotalW] ? tsp2lb_pkg::TotalMax : acc_sum[TotalW-1:0];
    miss_new = miss_q | !row_q.ok;
    out_load = b_take & row_q.mend;

    acc_d       = acc_q;
    miss_d      = miss_q;
    out_total_d = out_total_q;
    out_miss_d  = out_miss_q;
    out_valid_d = out_valid_q & !out_ready_i;
    if (b_take) begin
      if (row_q.mend) begin
        out_total_d = acc_sat;
        out_miss_d  = miss_new;
        out_valid_d = 1'b1;
        acc_d       = '0;
        miss_d      = 1'b0;
      end else begin
        acc_d  = acc_sat;
        miss_d = miss_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1v_q       <= 1'b0;
      f2v_q       <= 1'b0;
      icnt_q      <= 2'd0;
      row_v_q     <= 1'b0;
      acc_q       <= '0;
      miss_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      f1v_q       <= f1v_d;
      f2v_q       <= f2v_d;
      icnt_q      <= icnt_d;
      row_v_q     <= row_v_d;
      acc_q       <= acc_d;
      miss_q      <= miss_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q   <= f1_d;
    f2_q   <= f2_d;
    inc1_q <= inc1_d;
    inc2_q <= inc2_d;
    row_q  <= row_d;
    if (out_load) begin
      out_total_q <= out_total_d;
      out_miss_q  <= out_miss_d;
    end
  end

  // Half the total, rounded up, saturated to the bound width.
  assign half_up = TotalW'(out_total_q[TotalW-1:1]) + TotalW'(out_total_q[0]);

  assign out_valid_o   = out_valid_q;
  assign no_bound_o    = out_miss_q;
  assign lower_bound_o = out_miss_q     ? '0 :
                         half_up[BoundW] ? tsp2lb_pkg::BoundMax : half_up[BoundW-1:0];

endmodule

// ===== hdl/tsp_two_edge_lower_bound_core.sv =====
// Top level of the edge-pair TSP lower bound block.
// Throughput: one matrix entry per cycle, sustained while the result is taken.
// Path: a matrix-end entry passes the queue register, the row stage and the
// accumulator/result register before its result is valid.
// A held result stalls the back end only when a further matrix end reaches it.
// Reset (async, active low) empties the queue and clears row state and totals.
module tsp_two_edge_lower_bound_core #(
  parameter int unsigned COST_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tsp2lb_pkg::CostW-1:0]      edge_cost_i,
  input  logic [tsp2lb_pkg::MarkW-1:0]      edge_mark_i,
  input  logic                              row_end_i,
  input  logic                              matrix_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tsp2lb_pkg::BoundW-1:0]     lower_bound_o,
  output logic                              no_bound_o
);

  tsp2lb_pkg::entry_t ent;
  logic               ent_valid, ent_pop;

  tsp2lb_front #(
    .COST_BITS(COST_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .edge_cost_i (edge_cost_i),
    .edge_mark_i (edge_mark_i),
    .row_end_i   (row_end_i),
    .matrix_end_i(matrix_end_i),
    .ent_valid_o (ent_valid),
    .ent_o       (ent),
    .ent_pop_i   (ent_pop)
  );

  tsp2lb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ent_valid_i  (ent_valid),
    .ent_i        (ent),
    .ent_pop_o    (ent_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .lower_bound_o(lower_bound_o),
    .no_bound_o   (no_bound_o)
  );

endmodule

// ===== hdl/tsp2lb_checker.sv =====
// Port-level checks for the edge-pair TSP lower bound block, bound to the top level.
module tsp2lb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          matrix_end_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [tsp2lb_pkg::BoundW-1:0] lower_bound_o,
  input logic                          no_bound_o
);

  localparam int unsigned MaxPending = 4;

  logic [2:0] pending_q, pending_d;
  logic       in_mend, out_xfer;

  // Count matrix ends accepted but not yet delivered as a result transfer.
  assign in_mend  = in_valid_i & in_ready_o & matrix_end_i;
  assign out_xfer = out_valid_o & out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_mend && !out_xfer) begin
      pending_d = 3'(pending_q + 1'b1);
    end else if (out_xfer && !in_mend) begin
      pending_d = 3'(pending_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(lower_bound_o) && $stable(no_bound_o))
    else $error("result changed while stalled");

  a_no_bound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_bound_o |-> lower_bound_o == '0)
    else $error("no_bound result carries a nonzero bound");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result without a pending matrix end");

  a_pending_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'(MaxPending))
    else $error("too many matrix ends in flight");

endmodule

bind tsp_two_edge_lower_bound_core tsp2lb_checker u_tsp2lb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .matrix_end_i (matrix_end_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .lower_bound_o(lower_bound_o),
  .no_bound_o   (no_bound_o)
);
